[hdl/mstt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mstt_pkg;

   localparam int NUM_TIMERS = 8;

   localparam int IDX_W   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W   = $clog2(NUM_TIMERS + 1);
   localparam int TICK_W  = 16;
   localparam int SLOT_W  = 4;

   // reply slot when no slot is free, masked to the field width
   localparam logic [SLOT_W-1:0] SLOT_FULL = SLOT_W'(NUM_TIMERS % (1 << SLOT_W));

   localparam logic [1:0] CMD_REGISTER = 2'd0;
   localparam logic [1:0] CMD_DELETE   = 2'd1;
   localparam logic [1:0] CMD_TICK     = 2'd2;

   localparam logic EVT_REPLY  = 1'b0;
   localparam logic EVT_EXPIRY = 1'b1;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [7:0]        slot_index;
      logic [TICK_W-1:0] start_ticks;
      logic [TICK_W-1:0] reload_ticks;
   } req_type;

   typedef struct packed {
      logic              event_kind;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } rsp_type;

   // slot number as carried in a result beat
   function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
      logic [IDX_W+SLOT_W-1:0] ext;
      ext = (IDX_W + SLOT_W)'(idx);
      return ext[SLOT_W-1:0];
   endfunction

endpackage

`default_nettype wire

[hdl/multi_slot_timer_table_top.sv]
// register/delete/unused commands: handled in idle; a register reply appears the next cycle
// tick: walks the slot memory, reading every slot and writing back each active slot,
//   then emits one expiry beat per cycle while rsp_ready is high
// new commands wait while a tick walks the slot memory (one read port, one write port)
// reset (synchronous, active high) frees all slots and clears control; memory is not cleared
`timescale 1ns / 1ps
`default_nettype none

module multi_slot_timer_table_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mstt_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mstt_pkg::rsp_type      rsp_payload
);
   import mstt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [NUM_TIMERS-1:0] active_ff, active_in;
   logic [NUM_TIMERS-1:0] expire_ff, expire_in;
   logic [CNT_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic                  pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]      pend_idx_ff, pend_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   // slot memory: {reload, remaining}
   logic [2*TICK_W-1:0] tmr_mem [NUM_TIMERS];
   logic [2*TICK_W-1:0] rd_data_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [2*TICK_W-1:0] mem_wdata;
   logic [IDX_W-1:0]    mem_raddr;

   logic                  req_fire;
   logic                  out_free;
   logic                  free_found;
   logic [IDX_W-1:0]      free_idx;
   logic [IDX_W-1:0]      emit_idx;
   logic [NUM_TIMERS-1:0] emit_rest;
   logic [TICK_W-1:0]     rem_cur, rel_cur, rem_dec;
   logic                  pend_active, pend_hit;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // lowest pending expiry
   always_comb begin
      emit_idx = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (expire_ff[i]) begin
            emit_idx = IDX_W'(i);
         end
      end
      emit_rest = expire_ff;
      emit_rest[emit_idx] = 1'b0;
   end

   assign rem_cur     = rd_data_ff[TICK_W-1:0];
   assign rel_cur     = rd_data_ff[2*TICK_W-1:TICK_W];
   assign rem_dec     = (rem_cur != '0) ? rem_cur - TICK_W'(1) : rem_cur;
   assign pend_active = pend_vld_ff && active_ff[pend_idx_ff];
   assign pend_hit    = pend_active && (rem_dec == '0);
   assign mem_raddr   = rd_cnt_ff[IDX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      expire_in    = expire_ff;
      rd_cnt_in    = rd_cnt_ff;
      pend_vld_in  = 1'b0;
      pend_idx_in  = pend_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = free_idx;
      mem_wdata    = {req_payload.reload_ticks, req_payload.start_ticks};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               priority if (req_payload.cmd == CMD_REGISTER) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in.event_kind = EVT_REPLY;
                  rsp_in.last      = 1'b1;
                  if (free_found) begin
                     rsp_in.slot         = to_slot(free_idx);
                     active_in[free_idx] = 1'b1;
                     mem_we              = 1'b1;
                  end else begin
                     rsp_in.slot = SLOT_FULL;
                  end
               end else if (req_payload.cmd == CMD_DELETE) begin
                  if ({1'b0, req_payload.slot_index} < 9'(NUM_TIMERS)) begin
                     active_in[IDX_W'(req_payload.slot_index)] = 1'b0;
                  end
               end else if (req_payload.cmd == CMD_TICK) begin
                  rd_cnt_in = '0;
                  expire_in = '0;
                  state_in  = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            if (rd_cnt_ff != CNT_W'(NUM_TIMERS)) begin
               pend_vld_in = 1'b1;
               pend_idx_in = rd_cnt_ff[IDX_W-1:0];
               rd_cnt_in   = rd_cnt_ff + CNT_W'(1);
            end
            // write-back of the slot read last cycle; never the slot being read now
            if (pend_active) begin
               mem_we    = 1'b1;
               mem_waddr = pend_idx_ff;
               mem_wdata = {rel_cur, pend_hit ? rel_cur : rem_dec};
               if (pend_hit) begin
                  expire_in[pend_idx_ff] = 1'b1;
                  if (rel_cur == '0) begin
                     active_in[pend_idx_ff] = 1'b0;
                  end
               end
            end
            if (rd_cnt_ff == CNT_W'(NUM_TIMERS) && !pend_vld_ff) begin
               state_in = (expire_ff != '0) ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.event_kind = EVT_EXPIRY;
               rsp_in.slot       = to_slot(emit_idx);
               rsp_in.last       = (emit_rest == '0);
               expire_in         = emit_rest;
               if (emit_rest == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         expire_ff    <= '0;
         rd_cnt_ff    <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         expire_ff    <= expire_in;
         rd_cnt_ff    <= rd_cnt_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tmr_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= tmr_mem[mem_raddr];
   end

endmodule

`default_nettype wire

[hdl/mstt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module mstt_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire mstt_pkg::req_type req_payload,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire mstt_pkg::rsp_type rsp_payload
);
   import mstt_pkg::*;

   // stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat dropped or changed");

   // a stalled output blocks new commands
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("command accepted while result stalled");

   // register command answers with a single reply beat next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.cmd == CMD_REGISTER |=>
         rsp_valid && rsp_payload.event_kind == EVT_REPLY && rsp_payload.last)
      else $error("missing register reply");

   // a tick occupies the block while it walks the slots
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.cmd == CMD_TICK |=> !req_ready)
      else $error("command accepted during tick walk");

endmodule

bind multi_slot_timer_table_top mstt_checker u_mstt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
